@@ hdl/ecsm_pkg.sv @@
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared widths, register indexes, payload types and modular add/subtract
// helpers for the elliptic-curve scalar multiplier.
// ----------------------------------------------------------------------------
package ecsm_pkg;

   localparam int COORD_BITS  = 16;
   localparam int SCALAR_BITS = 16;
   localparam int STEP_BITS   = $clog2(SCALAR_BITS + 1);
   localparam int ITER_BITS   = $clog2(COORD_BITS + 1);
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MODULUS = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_CURVE_A = CSR_IDX_BITS'(1);

   localparam logic [COORD_BITS-1:0] MODULUS_RESET = COORD_BITS'(167);
   localparam logic [COORD_BITS-1:0] CURVE_A_RESET = COORD_BITS'(11);
   localparam logic [COORD_BITS-1:0] MODULUS_MIN   = COORD_BITS'(3);
   localparam logic [COORD_BITS-1:0] COEF_THREE    = COORD_BITS'(3);

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]  base_x;
      logic [COORD_BITS-1:0]  base_y;
      logic                   base_is_infinity;
      logic [SCALAR_BITS-1:0] scalar;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] res_x;
      logic [COORD_BITS-1:0] res_y;
      logic                  res_is_infinity;
   } rsp_type;

   function automatic coord_type add_mod(coord_type a, coord_type b, coord_type p);
      logic [COORD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, p}) begin
         s = s - {1'b0, p};
      end
      return s[COORD_BITS-1:0];
   endfunction

   function automatic coord_type sub_mod(coord_type a, coord_type b, coord_type p);
      logic [COORD_BITS:0] s;
      if (a >= b) begin
         s = {1'b0, a} - {1'b0, b};
      end else begin
         s = {1'b0, a} + {1'b0, p} - {1'b0, b};
      end
      return s[COORD_BITS-1:0];
   endfunction

endpackage

@@ hdl/ecsm_mul.sv @@
// ----------------------------------------------------------------------------
// ecsm_mul
// Bit-serial modular multiplier: a * b mod p, one bit of b per cycle,
// most significant bit first. Operand a must be below p.
// ----------------------------------------------------------------------------
module ecsm_mul
   import ecsm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  coord_type a,
   input  coord_type b,
   input  coord_type p,
   output logic      done,
   output coord_type prod
);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [ITER_BITS-1:0]  cnt_ff, cnt_in;
   coord_type             acc_ff, acc_in;
   coord_type             a_ff, a_in;
   coord_type             b_ff, b_in;
   logic [COORD_BITS:0]   dbl;
   logic [COORD_BITS:0]   sum;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      dbl = {acc_ff, 1'b0};
      if (dbl >= {1'b0, p}) begin
         dbl = dbl - {1'b0, p};
      end
      sum = dbl + (b_ff[COORD_BITS-1] ? {1'b0, a_ff} : '0);
      if (sum >= {1'b0, p}) begin
         sum = sum - {1'b0, p};
      end
      if (start) begin
         run_in = 1'b1;
         cnt_in = ITER_BITS'(COORD_BITS);
         acc_in = '0;
         a_in   = a;
         b_in   = b;
      end else if (run_ff) begin
         acc_in = sum[COORD_BITS-1:0];
         b_in   = {b_ff[COORD_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - ITER_BITS'(1);
         if (cnt_ff == ITER_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

@@ hdl/ecsm_div.sv @@
// ----------------------------------------------------------------------------
// ecsm_div
// Bit-serial restoring divider: one quotient bit per cycle, giving quotient
// and remainder. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module ecsm_div
   import ecsm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  coord_type dividend,
   input  coord_type divisor,
   output logic      done,
   output coord_type quo,
   output coord_type rem
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [ITER_BITS-1:0] cnt_ff, cnt_in;
   coord_type            rem_ff, rem_in;
   coord_type            quo_ff, quo_in;
   coord_type            dsr_ff, dsr_in;
   logic [COORD_BITS:0]  trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[COORD_BITS-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = ITER_BITS'(COORD_BITS);
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            trial  = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[COORD_BITS-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[COORD_BITS-2:0], 1'b0};
         end
         rem_in = trial[COORD_BITS-1:0];
         cnt_in = cnt_ff - ITER_BITS'(1);
         if (cnt_ff == ITER_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

endmodule

@@ hdl/ec_point_scalar_multiply_top.sv @@
// ----------------------------------------------------------------------------
// ec_point_scalar_multiply_top
// Scalar multiplication n*P on y^2 = x^3 + a*x + b over GF(p), affine
// double-and-add with the point at infinity carried as a flag.
//
// Usage:
//   Write modulus (index 0) and curve_a (index 1) through csr_we/csr_index/
//   csr_wdata while the block is idle. Present a base point and scalar on
//   req_data with start high; the item transfers when busy is low. busy stays
//   high until the result is out. The result is on rsp_data for one cycle
//   with rsp_strobe high; the receiver cannot stall it.
//   Sequence: 3 reductions mod p through the divider, then for each of the
//   SCALAR_BITS scalar bits one doubling and, for a set bit, one addition.
//   A point operation with an inverse runs extended-Euclid rounds (up to
//   about 24 rounds for 16-bit moduli); the shared bit-serial multiplier
//   and divider set the pace. With a modulus below 3 the block goes from
//   idle straight to the output state and strobes the infinity result.
//   One item is in flight at a time.
//   Reset returns the registers to modulus 167 and a = 11, and idles.
// ----------------------------------------------------------------------------
module ec_point_scalar_multiply_top
   import ecsm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  req_type                 req_data,
   output logic                    rsp_strobe,
   output rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  coord_type               csr_wdata
);

   localparam int ST_BITS = 5;
   localparam logic [ST_BITS-1:0] ST_IDLE      = 5'd0;
   localparam logic [ST_BITS-1:0] ST_RED_X     = 5'd1;
   localparam logic [ST_BITS-1:0] ST_RED_Y     = 5'd2;
   localparam logic [ST_BITS-1:0] ST_RED_A     = 5'd3;
   localparam logic [ST_BITS-1:0] ST_BIT       = 5'd4;
   localparam logic [ST_BITS-1:0] ST_PT_BEGIN  = 5'd5;
   localparam logic [ST_BITS-1:0] ST_DBL_SQ    = 5'd6;
   localparam logic [ST_BITS-1:0] ST_DBL_3     = 5'd7;
   localparam logic [ST_BITS-1:0] ST_INV_BEGIN = 5'd8;
   localparam logic [ST_BITS-1:0] ST_EU_DIV    = 5'd9;
   localparam logic [ST_BITS-1:0] ST_EU_MUL    = 5'd10;
   localparam logic [ST_BITS-1:0] ST_SLOPE     = 5'd11;
   localparam logic [ST_BITS-1:0] ST_X3        = 5'd12;
   localparam logic [ST_BITS-1:0] ST_Y3_GO     = 5'd13;
   localparam logic [ST_BITS-1:0] ST_Y3        = 5'd14;
   localparam logic [ST_BITS-1:0] ST_PT_END    = 5'd15;
   localparam logic [ST_BITS-1:0] ST_OUT       = 5'd16;

   logic [ST_BITS-1:0]     state_ff, state_in;
   coord_type              modulus_ff, modulus_in;
   coord_type              curve_a_ff, curve_a_in;
   coord_type              ca_ff, ca_in;
   coord_type              hold_x_ff, hold_x_in;
   coord_type              hold_y_ff, hold_y_in;
   logic                   hold_inf_ff, hold_inf_in;
   coord_type              acc_x_ff, acc_x_in;
   coord_type              acc_y_ff, acc_y_in;
   logic                   acc_inf_ff, acc_inf_in;
   coord_type              r_x_ff, r_x_in;
   coord_type              r_y_ff, r_y_in;
   logic                   r_inf_ff, r_inf_in;
   logic [SCALAR_BITS-1:0] scalar_ff, scalar_in;
   logic [STEP_BITS-1:0]   steps_ff, steps_in;
   logic                   bit_ff, bit_in;
   logic                   add_phase_ff, add_phase_in;
   coord_type              num_ff, num_in;
   coord_type              r0_ff, r0_in;
   coord_type              r1_ff, r1_in;
   coord_type              t0_ff, t0_in;
   coord_type              t1_ff, t1_in;
   coord_type              sl_ff, sl_in;
   coord_type              x3_ff, x3_in;
   logic                   mul_go_ff, mul_go_in;
   coord_type              mul_a_ff, mul_a_in;
   coord_type              mul_b_ff, mul_b_in;
   logic                   div_go_ff, div_go_in;
   coord_type              div_n_ff, div_n_in;
   coord_type              div_d_ff, div_d_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic      mul_done;
   coord_type mul_prod;
   logic      div_done;
   coord_type div_quo;
   coord_type div_rem;

   ecsm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_go_ff),
      .a     (mul_a_ff),
      .b     (mul_b_ff),
      .p     (modulus_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   ecsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (div_n_ff),
      .divisor  (div_d_ff),
      .done     (div_done),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   always_comb begin
      state_in      = state_ff;
      modulus_in    = modulus_ff;
      curve_a_in    = curve_a_ff;
      ca_in         = ca_ff;
      hold_x_in     = hold_x_ff;
      hold_y_in     = hold_y_ff;
      hold_inf_in   = hold_inf_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      acc_inf_in    = acc_inf_ff;
      r_x_in        = r_x_ff;
      r_y_in        = r_y_ff;
      r_inf_in      = r_inf_ff;
      scalar_in     = scalar_ff;
      steps_in      = steps_ff;
      bit_in        = bit_ff;
      add_phase_in  = add_phase_ff;
      num_in        = num_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      t0_in         = t0_ff;
      t1_in         = t1_ff;
      sl_in         = sl_ff;
      x3_in         = x3_ff;
      mul_go_in     = 1'b0;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      div_go_in     = 1'b0;
      div_n_in      = div_n_ff;
      div_d_in      = div_d_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS: modulus_in = csr_wdata;
            CSR_CURVE_A: curve_a_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               scalar_in   = req_data.scalar;
               hold_y_in   = req_data.base_y;
               hold_inf_in = req_data.base_is_infinity;
               acc_inf_in  = 1'b1;
               if (modulus_ff < MODULUS_MIN) begin
                  state_in = ST_OUT;
               end else begin
                  div_go_in = 1'b1;
                  div_n_in  = req_data.base_x;
                  div_d_in  = modulus_ff;
                  state_in  = ST_RED_X;
               end
            end
         end
         ST_RED_X: begin
            if (div_done) begin
               hold_x_in = div_rem;
               div_go_in = 1'b1;
               div_n_in  = hold_y_ff;
               state_in  = ST_RED_Y;
            end
         end
         ST_RED_Y: begin
            if (div_done) begin
               hold_y_in = div_rem;
               div_go_in = 1'b1;
               div_n_in  = curve_a_ff;
               state_in  = ST_RED_A;
            end
         end
         ST_RED_A: begin
            if (div_done) begin
               ca_in      = div_rem;
               acc_inf_in = 1'b1;
               steps_in   = STEP_BITS'(SCALAR_BITS);
               state_in   = ST_BIT;
            end
         end
         ST_BIT: begin
            steps_in     = steps_ff - STEP_BITS'(1);
            bit_in       = scalar_ff[SCALAR_BITS-1];
            scalar_in    = {scalar_ff[SCALAR_BITS-2:0], 1'b0};
            add_phase_in = 1'b0;
            r_x_in       = acc_x_ff;
            r_y_in       = acc_y_ff;
            r_inf_in     = acc_inf_ff;
            state_in     = ST_PT_BEGIN;
         end
         ST_PT_BEGIN: begin
            if (acc_inf_ff) begin
               acc_x_in   = r_x_ff;
               acc_y_in   = r_y_ff;
               acc_inf_in = r_inf_ff;
               state_in   = ST_PT_END;
            end else if (r_inf_ff) begin
               state_in = ST_PT_END;
            end else if (acc_x_ff == r_x_ff && acc_y_ff == r_y_ff) begin
               mul_go_in = 1'b1;
               mul_a_in  = acc_x_ff;
               mul_b_in  = acc_x_ff;
               state_in  = ST_DBL_SQ;
            end else begin
               num_in   = sub_mod(r_y_ff, acc_y_ff, modulus_ff);
               r1_in    = sub_mod(r_x_ff, acc_x_ff, modulus_ff);
               state_in = ST_INV_BEGIN;
            end
         end
         ST_DBL_SQ: begin
            if (mul_done) begin
               mul_go_in = 1'b1;
               mul_a_in  = mul_prod;
               mul_b_in  = COEF_THREE;
               state_in  = ST_DBL_3;
            end
         end
         ST_DBL_3: begin
            if (mul_done) begin
               num_in   = add_mod(mul_prod, ca_ff, modulus_ff);
               r1_in    = add_mod(acc_y_ff, acc_y_ff, modulus_ff);
               state_in = ST_INV_BEGIN;
            end
         end
         ST_INV_BEGIN: begin
            if (r1_ff == '0) begin
               acc_inf_in = 1'b1;
               state_in   = ST_PT_END;
            end else begin
               r0_in     = modulus_ff;
               t0_in     = '0;
               t1_in     = COORD_BITS'(1);
               div_go_in = 1'b1;
               div_n_in  = modulus_ff;
               div_d_in  = r1_ff;
               state_in  = ST_EU_DIV;
            end
         end
         ST_EU_DIV: begin
            if (div_done) begin
               r0_in     = r1_ff;
               r1_in     = div_rem;
               mul_go_in = 1'b1;
               mul_a_in  = t1_ff;
               mul_b_in  = div_quo;
               state_in  = ST_EU_MUL;
            end
         end
         ST_EU_MUL: begin
            if (mul_done) begin
               t0_in = t1_ff;
               t1_in = sub_mod(t0_ff, mul_prod, modulus_ff);
               if (r1_ff != '0) begin
                  div_go_in = 1'b1;
                  div_n_in  = r0_ff;
                  div_d_in  = r1_ff;
                  state_in  = ST_EU_DIV;
               end else if (r0_ff == COORD_BITS'(1)) begin
                  mul_go_in = 1'b1;
                  mul_a_in  = num_ff;
                  mul_b_in  = t1_ff;
                  state_in  = ST_SLOPE;
               end else begin
                  acc_inf_in = 1'b1;
                  state_in   = ST_PT_END;
               end
            end
         end
         ST_SLOPE: begin
            if (mul_done) begin
               sl_in     = mul_prod;
               mul_go_in = 1'b1;
               mul_a_in  = mul_prod;
               mul_b_in  = mul_prod;
               state_in  = ST_X3;
            end
         end
         ST_X3: begin
            if (mul_done) begin
               x3_in    = sub_mod(sub_mod(mul_prod, acc_x_ff, modulus_ff), r_x_ff,
                                  modulus_ff);
               state_in = ST_Y3_GO;
            end
         end
         ST_Y3_GO: begin
            mul_go_in = 1'b1;
            mul_a_in  = sl_ff;
            mul_b_in  = sub_mod(acc_x_ff, x3_ff, modulus_ff);
            state_in  = ST_Y3;
         end
         ST_Y3: begin
            if (mul_done) begin
               acc_x_in   = x3_ff;
               acc_y_in   = sub_mod(mul_prod, acc_y_ff, modulus_ff);
               acc_inf_in = 1'b0;
               state_in   = ST_PT_END;
            end
         end
         ST_PT_END: begin
            if (!add_phase_ff && bit_ff) begin
               add_phase_in = 1'b1;
               r_x_in       = hold_x_ff;
               r_y_in       = hold_y_ff;
               r_inf_in     = hold_inf_ff;
               state_in     = ST_PT_BEGIN;
            end else if (steps_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_BIT;
            end
         end
         ST_OUT: begin
            rsp_strobe_in               = 1'b1;
            rsp_data_in.res_is_infinity = acc_inf_ff;
            rsp_data_in.res_x           = acc_inf_ff ? '0 : acc_x_ff;
            rsp_data_in.res_y           = acc_inf_ff ? '0 : acc_y_ff;
            state_in                    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         modulus_ff    <= MODULUS_RESET;
         curve_a_ff    <= CURVE_A_RESET;
         mul_go_ff     <= 1'b0;
         div_go_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         modulus_ff    <= modulus_in;
         curve_a_ff    <= curve_a_in;
         mul_go_ff     <= mul_go_in;
         div_go_ff     <= div_go_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ca_ff        <= ca_in;
      hold_x_ff    <= hold_x_in;
      hold_y_ff    <= hold_y_in;
      hold_inf_ff  <= hold_inf_in;
      acc_x_ff     <= acc_x_in;
      acc_y_ff     <= acc_y_in;
      acc_inf_ff   <= acc_inf_in;
      r_x_ff       <= r_x_in;
      r_y_ff       <= r_y_in;
      r_inf_ff     <= r_inf_in;
      scalar_ff    <= scalar_in;
      steps_ff     <= steps_in;
      bit_ff       <= bit_in;
      add_phase_ff <= add_phase_in;
      num_ff       <= num_in;
      r0_ff        <= r0_in;
      r1_ff        <= r1_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      sl_ff        <= sl_in;
      x3_ff        <= x3_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      div_n_ff     <= div_n_in;
      div_d_ff     <= div_d_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not raise busy");

   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.res_is_infinity |-> rsp_data.res_x == '0 &&
         rsp_data.res_y == '0)
      else $error("infinity result with nonzero coordinates");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy && !$past(rsp_strobe))
      else $error("result strobe outside single idle cycle");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_RED_X || state_ff == ST_RED_Y ||
         state_ff == ST_RED_A || state_ff == ST_EU_DIV)
      else $error("divider finished outside a divide wait state");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the elliptic-curve scalar multiplier: a directed
// table of corner items, then randomized config phases and base points, with
// every transfer scored against its typed answer or a behavioral double-and-add model.
// ----------------------------------------------------------------------------
module tb_top;
   import ecsm_pkg::*;

   typedef struct {
      longint x;
      longint y;
      bit     inf;
   } ec_pt_t;

   typedef struct {
      logic [COORD_BITS-1:0] modulus;
      logic [COORD_BITS-1:0] curve_a;
      req_type               item;
      bit                    typed;
      rsp_type               answer;
   } vector_t;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   req_type                 req_data;
   logic                    rsp_strobe;
   rsp_type                 rsp_data;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   coord_type               csr_wdata;

   rsp_type               expected_points[$];
   int                    errors;
   logic [COORD_BITS-1:0] cur_modulus;
   logic [COORD_BITS-1:0] cur_curve_a;
   vector_t               vectors[$];

   ec_point_scalar_multiply_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #400_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic bit inverse_mod(longint v, longint pm, output longint inv);
      longint r0, r1, t0, t1, q, tr, tt;
      r0 = pm; r1 = v; t0 = 0; t1 = 1; inv = 0;
      while (r1 != 0) begin
         q = r0 / r1;
         tr = r0 - q * r1;
         tt = t0 - q * t1;
         r0 = r1; r1 = tr;
         t0 = t1; t1 = tt;
      end
      if (r0 != 1) return 1'b0;
      if (t0 < 0) t0 += pm;
      inv = t0 % pm;
      return 1'b1;
   endfunction

   function automatic longint sub_field(longint u, longint v, longint pm);
      return (u + pm - v) % pm;
   endfunction

   function automatic ec_pt_t add_points(ec_pt_t q, ec_pt_t r, longint pm, longint ca);
      ec_pt_t s;
      longint num, den, inv, sl, x3, y3;
      s.x = 0; s.y = 0; s.inf = 1'b1;
      if (q.inf) return r;
      if (r.inf) return q;
      if (q.x == r.x && q.y == r.y) begin
         num = ((q.x * q.x) % pm * 3 + ca) % pm;
         den = (2 * q.y) % pm;
      end else begin
         num = sub_field(r.y, q.y, pm);
         den = sub_field(r.x, q.x, pm);
      end
      if (den == 0 || !inverse_mod(den, pm, inv)) return s;
      sl = (num * inv) % pm;
      x3 = sub_field(sub_field((sl * sl) % pm, q.x, pm), r.x, pm);
      y3 = sub_field((sl * sub_field(q.x, x3, pm)) % pm, q.y, pm);
      s.x = x3; s.y = y3; s.inf = 1'b0;
      return s;
   endfunction

   function automatic rsp_type scalar_product(req_type it);
      rsp_type r;
      ec_pt_t  base, acc;
      longint  pm, ca;
      r = '0;
      r.res_is_infinity = 1'b1;
      pm = cur_modulus;
      if (pm < 3) return r;
      ca = cur_curve_a % pm;
      base.x = it.base_x % pm;
      base.y = it.base_y % pm;
      base.inf = it.base_is_infinity;
      acc.x = 0; acc.y = 0; acc.inf = 1'b1;
      for (int b = SCALAR_BITS - 1; b >= 0; b--) begin
         acc = add_points(acc, acc, pm, ca);
         if (it.scalar[b]) acc = add_points(acc, base, pm, ca);
      end
      if (!acc.inf) begin
         r.res_x = acc.x[COORD_BITS-1:0];
         r.res_y = acc.y[COORD_BITS-1:0];
         r.res_is_infinity = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.res_x !== want.res_x)
               report_mismatch("res_x", rsp_data.res_x, want.res_x);
            if (rsp_data.res_y !== want.res_y)
               report_mismatch("res_y", rsp_data.res_y, want.res_y);
            if (rsp_data.res_is_infinity !== want.res_is_infinity)
               report_mismatch("res_is_infinity", rsp_data.res_is_infinity,
                               want.res_is_infinity);
         end
      end
   end

   task automatic drain_block();
      start <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, coord_type val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_MODULUS) cur_modulus = val;
      else cur_curve_a = val;
   endtask

   task automatic set_curve(coord_type m, coord_type a);
      if (m == cur_modulus && a == cur_curve_a) return;
      drain_block();
      write_reg(CSR_MODULUS, m);
      write_reg(CSR_CURVE_A, a);
   endtask

   // hold start high until the item transfers
   task automatic send_item(req_type it, bit typed, rsp_type answer, bit idle_ok);
      if (idle_ok && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_points.push_back(typed ? answer : scalar_product(it));
   endtask

   function automatic void add_vector(coord_type m, coord_type a, coord_type x, coord_type y,
                                      bit inf, logic [SCALAR_BITS-1:0] n, bit typed,
                                      coord_type ex, coord_type ey, bit einf);
      vector_t v;
      v.modulus = m; v.curve_a = a;
      v.item.base_x = x; v.item.base_y = y;
      v.item.base_is_infinity = inf; v.item.scalar = n;
      v.typed = typed;
      v.answer.res_x = ex; v.answer.res_y = ey; v.answer.res_is_infinity = einf;
      vectors.push_back(v);
   endfunction

   function automatic coord_type pick_modulus();
      coord_type primes[8] = '{5, 7, 13, 31, 97, 167, 251, 1021};
      case ($urandom_range(0, 9))
         0:       return coord_type'($urandom_range(0, 2));
         1:       return coord_type'($urandom_range(3, 65535));
         2:       return 16'd65521;
         default: return primes[$urandom_range(0, 7)];
      endcase
   endfunction

   initial begin
      req_type               it;
      rsp_type               none;
      coord_type             m, a;
      int                    total;
      errors      = 0;
      cur_modulus = MODULUS_RESET;
      cur_curve_a = CURVE_A_RESET;
      none        = '0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_vector(167, 11, 5, 10, 0, 0, 1, 0, 0, 1);
      add_vector(167, 11, 5, 10, 1, 5, 1, 0, 0, 1);
      add_vector(167, 11, 5, 10, 0, 1, 1, 5, 10, 0);
      add_vector(167, 11, 200, 300, 0, 1, 1, 33, 133, 0);
      add_vector(167, 11, 42, 0, 0, 2, 1, 0, 0, 1);
      add_vector(167, 11, 5, 10, 0, 2, 0, 0, 0, 0);
      add_vector(167, 11, 5, 10, 0, 3, 0, 0, 0, 0);
      add_vector(167, 11, 65535, 65535, 0, 16'hFFFF, 0, 0, 0, 0);
      add_vector(167, 11, 0, 0, 0, 16'h8000, 0, 0, 0, 0);
      add_vector(2, 11, 1, 1, 0, 16'hFFFF, 1, 0, 0, 1);
      add_vector(0, 0, 65535, 65535, 1, 16'hFFFF, 1, 0, 0, 1);
      add_vector(3, 65535, 1, 2, 0, 16'h5555, 0, 0, 0, 0);
      add_vector(3, 0, 2, 1, 0, 1, 1, 2, 1, 0);
      add_vector(65535, 65535, 12345, 54321, 0, 16'hAAAA, 0, 0, 0, 0);
      add_vector(65521, 0, 65535, 1, 0, 16'hFFFF, 0, 0, 0, 0);
      add_vector(65521, 65520, 4, 9, 0, 1, 1, 4, 9, 0);
      add_vector(97, 2, 3, 6, 0, 97, 0, 0, 0, 0);

      foreach (vectors[i]) begin
         set_curve(vectors[i].modulus, vectors[i].curve_a);
         send_item(vectors[i].item, vectors[i].typed, vectors[i].answer, 1'b1);
      end

      total = 123;
      for (int k = 0; k < total; k++) begin
         if (k % 20 == 0) begin
            m = pick_modulus();
            a = ($urandom_range(0, 3) == 0) ? coord_type'($urandom)
                : coord_type'($urandom_range(0, (m > 1) ? m - 1 : 0));
            drain_block();
            set_curve(m, a);
         end
         if ($urandom_range(0, 4) == 0) begin
            it.base_x = coord_type'($urandom);
            it.base_y = coord_type'($urandom);
         end else begin
            it.base_x = coord_type'($urandom_range(0, (cur_modulus > 1) ? cur_modulus - 1 : 0));
            it.base_y = coord_type'($urandom_range(0, (cur_modulus > 1) ? cur_modulus - 1 : 0));
         end
         it.base_is_infinity = ($urandom_range(0, 9) == 0);
         it.scalar = SCALAR_BITS'($urandom);
         send_item(it, 1'b0, none, k < total - 20);
      end
      start <= 1'b0;

      while (expected_points.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/ecsm_pkg.sv
hdl/ecsm_mul.sv
hdl/ecsm_div.sv
hdl/ec_point_scalar_multiply_top.sv
sim/tb_top.sv
